FILE: hw/rtl/tree_entry_stream_parser_core_assert.svh
// Assertion macros for the tree entry parser checks.
`ifndef TREE_ENTRY_STREAM_PARSER_CORE_ASSERT_SVH
`define TREE_ENTRY_STREAM_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TESP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TESP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tesp_pkg.sv
package tesp_pkg;

  localparam int unsigned     MAX_NAME_LEN = 4095;
  localparam longint unsigned MAX_ENTRIES  = 64'd65535;

  localparam logic [11:0] NAME_CAP  =
    (MAX_NAME_LEN < 4095) ? 12'(MAX_NAME_LEN) : 12'd4095;
  localparam logic [15:0] ENTRY_CAP =
    (MAX_ENTRIES < 64'd65535) ? 16'(MAX_ENTRIES) : 16'hFFFF;

  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [2:0] KIND_MODE  = 3'd0;
  localparam logic [2:0] KIND_SPACE = 3'd1;
  localparam logic [2:0] KIND_NAME  = 3'd2;
  localparam logic [2:0] KIND_NEND  = 3'd3;
  localparam logic [2:0] KIND_ID    = 3'd4;
  localparam logic [2:0] KIND_DISC  = 3'd5;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_DIGIT = 3'd1;
  localparam logic [2:0] ERR_END_MODE  = 3'd2;
  localparam logic [2:0] ERR_END_NAME  = 3'd3;
  localparam logic [2:0] ERR_END_ID    = 3'd4;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_value;
    logic [11:0] field_offset;
    logic        entry_done;
    logic [31:0] entry_mode;
    logic [15:0] entry_index;
    logic [11:0] name_length;
    logic        error_flag;
    logic [2:0]  error_code;
    logic        object_done;
  } res_t;

endpackage

FILE: hw/rtl/tesp_in_reg.sv
module tesp_in_reg
  import tesp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  s_valid,
  input  logic  s_ready,
  output item_t s_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || s_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

FILE: hw/rtl/tesp_step.sv
module tesp_step
  import tesp_pkg::*;
#(
  parameter int unsigned OID_BYTES = 20
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  item_t s_item,
  output res_t  res
);

  localparam int unsigned IdW = (OID_BYTES > 1) ? $clog2(OID_BYTES) : 1;
  localparam logic [IdW-1:0] ID_LAST = IdW'(OID_BYTES - 1);

  localparam logic [1:0] PH_MODE = 2'd0;
  localparam logic [1:0] PH_NAME = 2'd1;
  localparam logic [1:0] PH_ID   = 2'd2;

  logic [1:0]     phase_r,    phase_nxt;
  logic [31:0]    acc_r,      acc_nxt;
  logic [IdW-1:0] id_off_r,   id_off_nxt;
  logic [11:0]    name_cnt_r, name_cnt_nxt;
  logic [15:0]    entry_r,    entry_nxt;
  logic           err_seen_r, err_seen_nxt;

  logic [7:0] b;
  logic       last;
  logic [2:0] kind;
  logic [2:0] err;

  assign b    = s_item.data_byte;
  assign last = s_item.last_byte;

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    id_off_nxt   = id_off_r;
    name_cnt_nxt = name_cnt_r;
    entry_nxt    = entry_r;
    err_seen_nxt = err_seen_r;
    kind         = KIND_DISC;
    err          = ERR_NONE;
    res          = '0;

    if (!err_seen_r) begin
      unique case (phase_r)
        PH_MODE: begin
          if (b == CH_SPACE) begin
            kind         = KIND_SPACE;
            phase_nxt    = PH_NAME;
            name_cnt_nxt = '0;
            if (last) err = ERR_END_NAME;
          end else if (b >= CH_0 && b <= CH_7) begin
            kind    = KIND_MODE;
            acc_nxt = {acc_r[28:0], b[2:0]};
            if (last) err = ERR_END_MODE;
          end else begin
            err = ERR_BAD_DIGIT;
          end
        end
        PH_NAME: begin
          res.field_offset = name_cnt_r;
          if (b != CH_NUL) begin
            kind = KIND_NAME;
            if (name_cnt_r < NAME_CAP) name_cnt_nxt = name_cnt_r + 12'd1;
            if (last) err = ERR_END_NAME;
          end else begin
            kind       = KIND_NEND;
            phase_nxt  = PH_ID;
            id_off_nxt = '0;
            if (last) err = ERR_END_ID;
          end
        end
        PH_ID: begin
          kind             = KIND_ID;
          res.field_offset = 12'(id_off_r);
          if (id_off_r == ID_LAST) begin
            res.entry_done  = 1'b1;
            res.entry_mode  = acc_r;
            res.entry_index = entry_r;
            res.name_length = name_cnt_r;
            if (entry_r < ENTRY_CAP) entry_nxt = entry_r + 16'd1;
            acc_nxt      = '0;
            id_off_nxt   = '0;
            name_cnt_nxt = '0;
            phase_nxt    = PH_MODE;
          end else begin
            id_off_nxt = id_off_r + IdW'(1);
            if (last) err = ERR_END_ID;
          end
        end
        default: begin
          phase_nxt = PH_MODE;
        end
      endcase
    end

    if (err != ERR_NONE) err_seen_nxt = 1'b1;

    if (last) begin
      phase_nxt    = PH_MODE;
      acc_nxt      = '0;
      id_off_nxt   = '0;
      name_cnt_nxt = '0;
      entry_nxt    = '0;
      err_seen_nxt = 1'b0;
    end

    res.byte_kind   = kind;
    res.byte_value  = b;
    res.error_flag  = (err != ERR_NONE);
    res.error_code  = err;
    res.object_done = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_MODE;
      acc_r      <= '0;
      id_off_r   <= '0;
      name_cnt_r <= '0;
      entry_r    <= '0;
      err_seen_r <= 1'b0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      id_off_r   <= id_off_nxt;
      name_cnt_r <= name_cnt_nxt;
      entry_r    <= entry_nxt;
      err_seen_r <= err_seen_nxt;
    end
  end

endmodule

FILE: hw/rtl/tesp_out_reg.sv
module tesp_out_reg
  import tesp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  res_t                   s_res,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign s_ready   = !valid_r || out_tready;
  assign valid_nxt = s_ready ? s_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      res_r <= s_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, res_r.error_code, res_r.error_flag, res_r.name_length,
                       res_r.entry_index, res_r.entry_mode, res_r.entry_done,
                       res_r.field_offset, res_r.byte_value};
  assign out_tuser  = res_r.byte_kind;
  assign out_tlast  = res_r.object_done;

endmodule

FILE: hw/rtl/tree_entry_stream_parser_core.sv
// Tree object entry parser, one content byte per item.
// Input channel in_*: in_tdata is the content byte, in_tlast marks the final
// byte of the object. Output channel out_*: one result item per input byte;
// out_tuser is the byte kind, out_tlast copies the input's last marker.
// Entry mode, index and name length ride on the item of the last id byte.
// The byte lands in the input register on accept, the parse step then loads the
// result register and out_tvalid rises.
// Throughput: one byte per cycle while out_tready does not stall the result
// register; the parse step updates its state once per accepted byte.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of an object; the final byte of an object does the same.
// A stall on out_tready holds the result; at most one more byte is taken
// into the input register, then in_tready drops until the result is taken.
module tree_entry_stream_parser_core
  import tesp_pkg::*;
#(
  parameter int unsigned OID_BYTES = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // byte_value, field_offset, entry_done, entry_mode, entry_index,
  // name_length, error_flag, error_code, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser,  // byte_kind
  output logic                   out_tlast
);

  item_t in_item;
  item_t s_item;
  logic  s_valid;
  logic  s_ready;
  res_t  s_res;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  tesp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_item   (s_item)
  );

  tesp_step #(
    .OID_BYTES (OID_BYTES)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s_valid && s_ready),
    .s_item (s_item),
    .res    (s_res)
  );

  tesp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_res      (s_res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/tesp_checker.sv
`include "tree_entry_stream_parser_core_assert.svh"

module tesp_checker
  import tesp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  `TESP_ASSERT_NOW(a_err_flag_code, out_tvalid, out_tdata[81] == (out_tdata[84:82] != ERR_NONE), "error flag and code disagree")
  `TESP_ASSERT_NOW(a_done_on_id, out_tvalid && out_tdata[20], out_tuser == KIND_ID && !out_tdata[81], "entry done on a byte that is not a clean id byte")
  `TESP_ASSERT_NOW(a_kind_range, out_tvalid, out_tuser <= KIND_DISC, "byte kind out of range")
  `TESP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind tree_entry_stream_parser_core tesp_checker u_tesp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import tesp_pkg::*;

  localparam int unsigned OID_N = 20;

  typedef enum logic [1:0] {
    PH_MODE,
    PH_NAME,
    PH_ID
  } parse_phase_e;

  class entry_parse_tracker;
    res_t         pending_results[$];
    int unsigned  oid_n;
    int           fails;
    int           matched;
    parse_phase_e ph;
    logic [31:0]  mode_acc;
    logic [11:0]  id_pos;
    logic [11:0]  name_cnt;
    logic [15:0]  entry_cnt;
    logic         err_seen;

    function new(int unsigned oid);
      oid_n   = oid;
      fails   = 0;
      matched = 0;
      restart();
    endfunction

    function void restart();
      ph        = PH_MODE;
      mode_acc  = '0;
      id_pos    = '0;
      name_cnt  = '0;
      entry_cnt = '0;
      err_seen  = 1'b0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 50) $display("mismatch: %s", msg);
    endtask

    // one expected result per accepted byte
    task take_byte(logic [7:0] b, logic last);
      res_t r;
      r             = '0;
      r.byte_kind   = KIND_DISC;
      r.byte_value  = b;
      r.error_code  = ERR_NONE;
      r.object_done = last;
      if (!err_seen) begin
        case (ph)
          PH_MODE: begin
            if (b == CH_SPACE) begin
              r.byte_kind = KIND_SPACE;
              ph          = PH_NAME;
              name_cnt    = '0;
              if (last) r.error_code = ERR_END_NAME;
            end else if (b >= CH_0 && b <= CH_7) begin
              r.byte_kind = KIND_MODE;
              mode_acc    = {mode_acc[28:0], 3'b000} + 32'(b - CH_0);
              if (last) r.error_code = ERR_END_MODE;
            end else begin
              r.error_code = ERR_BAD_DIGIT;
            end
          end
          PH_NAME: begin
            r.field_offset = name_cnt;
            if (b != CH_NUL) begin
              r.byte_kind = KIND_NAME;
              if (name_cnt < NAME_CAP) name_cnt++;
              if (last) r.error_code = ERR_END_NAME;
            end else begin
              r.byte_kind = KIND_NEND;
              ph          = PH_ID;
              id_pos      = '0;
              if (last) r.error_code = ERR_END_ID;
            end
          end
          default: begin
            r.byte_kind    = KIND_ID;
            r.field_offset = id_pos;
            id_pos         = id_pos + 12'd1;
            if (id_pos >= oid_n) begin
              r.entry_done  = 1'b1;
              r.entry_mode  = mode_acc;
              r.entry_index = entry_cnt;
              r.name_length = name_cnt;
              if (entry_cnt < ENTRY_CAP) entry_cnt++;
              mode_acc = '0;
              id_pos   = '0;
              name_cnt = '0;
              ph       = PH_MODE;
            end else if (last) begin
              r.error_code = ERR_END_ID;
            end
          end
        endcase
      end
      r.error_flag = (r.error_code != ERR_NONE);
      if (r.error_flag) err_seen = 1'b1;
      if (last) restart();
      pending_results.push_back(r);
    endtask

    task cmp(string fld, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", matched, fld, got, want));
    endtask

    task match_result(res_t got);
      res_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", matched));
        return;
      end
      e = pending_results.pop_front();
      cmp("byte_kind", 32'(got.byte_kind), 32'(e.byte_kind));
      cmp("byte_value", 32'(got.byte_value), 32'(e.byte_value));
      cmp("field_offset", 32'(got.field_offset), 32'(e.field_offset));
      cmp("entry_done", 32'(got.entry_done), 32'(e.entry_done));
      cmp("entry_mode", got.entry_mode, e.entry_mode);
      cmp("entry_index", 32'(got.entry_index), 32'(e.entry_index));
      cmp("name_length", 32'(got.name_length), 32'(e.name_length));
      cmp("error_flag", 32'(got.error_flag), 32'(e.error_flag));
      cmp("error_code", 32'(got.error_code), 32'(e.error_code));
      cmp("object_done", 32'(got.object_done), 32'(e.object_done));
      matched++;
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  entry_parse_tracker tracker;
  logic [7:0]         obj_q[$];
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 rx_hold_left;

  tree_entry_stream_parser_core #(
    .OID_BYTES(OID_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.byte_kind    = out_tuser[2:0];
        got.byte_value   = out_tdata[7:0];
        got.field_offset = out_tdata[19:8];
        got.entry_done   = out_tdata[20];
        got.entry_mode   = out_tdata[52:21];
        got.entry_index  = out_tdata[68:53];
        got.name_length  = out_tdata[80:69];
        got.error_flag   = out_tdata[81];
        got.error_code   = out_tdata[84:82];
        got.object_done  = out_tlast;
        tracker.match_result(got);
      end
      if (in_tvalid && in_tready) tracker.take_byte(in_tdata, in_tlast);
    end
  end

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) obj_q.push_back(s[i]);
  endtask

  task automatic push_fill(logic [7:0] v, int n);
    repeat (n) obj_q.push_back(v);
  endtask

  task automatic push_rand(int n);
    repeat (n) obj_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic push_entry(int digit_cnt, int name_len);
    repeat (digit_cnt) obj_q.push_back(CH_0 + 8'($urandom_range(7)));
    obj_q.push_back(CH_SPACE);
    repeat (name_len) obj_q.push_back(8'($urandom_range(1, 255)));
    obj_q.push_back(CH_NUL);
    push_rand(OID_N);
  endtask

  task automatic send_object();
    for (int i = 0; i < obj_q.size(); i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= obj_q[i];
      in_tlast  <= (i == obj_q.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    obj_q.delete();
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (tracker.pending() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic build_random_object();
    int n_ent;
    int mlen;
    int cut;
    int pos;
    n_ent = $urandom_range(1, 4);
    repeat (n_ent) begin
      mlen = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 7);
      push_entry(mlen, ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 16));
    end
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: begin
          cut = $urandom_range(1, obj_q.size() - 1);
          while (obj_q.size() > cut) void'(obj_q.pop_back());
        end
        1: begin
          pos = $urandom_range(obj_q.size() - 1);
          obj_q[pos] = 8'($urandom_range(255));
        end
        2: push_rand($urandom_range(1, 6));
        default: begin
          obj_q.delete();
          push_rand($urandom_range(1, 8));
        end
      endcase
    end
  endtask

  task automatic random_phase(int tx_pct, int rx_pct, int n_items);
    int sent;
    sent        = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      build_random_object();
      sent += obj_q.size();
      send_object();
    end
    wait_drained();
  endtask

  initial begin
    tracker      = new(OID_N);
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    tx_idle_pct  = 10;
    rx_idle_pct  = 10;
    rx_hold_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two full entries, id bytes at both extremes
    push_str("100644 a");
    obj_q.push_back(CH_NUL);
    push_fill(8'h00, OID_N);
    push_str("40000 dir");
    obj_q.push_back(CH_NUL);
    push_fill(8'hFF, OID_N);
    send_object();
    // empty mode
    push_str(" x");
    obj_q.push_back(CH_NUL);
    push_rand(OID_N);
    send_object();
    // bad mode digit, then discarded bytes
    push_str("18ab");
    send_object();
    // stream ends in mode, on the space, in name, on name end, in id
    push_str("100");
    send_object();
    push_str("644 ");
    send_object();
    push_str("644 ab");
    send_object();
    push_str("644 ab");
    obj_q.push_back(CH_NUL);
    send_object();
    push_str("644 a");
    obj_q.push_back(CH_NUL);
    push_rand(7);
    send_object();
    // bad digit on the final byte, and a one-byte object
    push_str("69");
    send_object();
    obj_q.push_back(8'hFF);
    send_object();
    // mode wraps past 32 bits
    push_str("77777777777777 z");
    obj_q.push_back(CH_NUL);
    push_rand(OID_N);
    send_object();
    wait_drained();

    // long receiver hold-off with the sender pushing flat out
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rx_hold_left = 250;
    repeat (4) push_entry($urandom_range(1, 6), $urandom_range(1, 8));
    send_object();
    wait_drained();

    random_phase(25, 51, 500);
    random_phase(51, 25, 500);
    random_phase(0, 0, 500);

    if (tracker.pending() > 0)
      tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));
    repeat (10) @(posedge clk);
    if (tracker.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tesp_pkg.sv
hw/rtl/tesp_in_reg.sv
hw/rtl/tesp_step.sv
hw/rtl/tesp_out_reg.sv
hw/rtl/tree_entry_stream_parser_core.sv
hw/rtl/tesp_checker.sv
tb/tb_top.sv
